[hdl/qpsf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpsf_pkg
// Types and constants shared by the quintic profile follower.
// ----------------------------------------------------------------------------
package qpsf_pkg;

  localparam int PosW  = 24;
  localparam int TimeW = 32;

  typedef struct packed {
    logic signed [PosW-1:0]  measured_position;
    logic signed [PosW-1:0]  commanded_position;
    logic [TimeW-1:0]        time_now;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive_power;
    logic               move_done;
  } out_t;

  typedef enum logic [1:0] {
    REG_GAIN     = 2'd0,
    REG_DURATION = 2'd1,
    REG_TOL      = 2'd2
  } reg_e;

  // Sequencer phases.
  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_T2, ST_T3, ST_INNER, ST_P, ST_TGT, ST_SQRT, ST_GAIN, ST_OUT
  } state_e;

  // Shared serial multiplier request.
  typedef struct packed {
    logic        start;
    logic [40:0] a;
    logic [40:0] b;
  } mul_req_t;

  localparam int MulW = 41;
endpackage

`default_nettype wire

[hdl/quintic_profile_sqrt_feedback_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quintic_profile_sqrt_feedback_top
// Quintic 3-4-5 trajectory follower with square-root position feedback.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. While a move runs, a result follows its input
// beat through a setup step, the tau divider, five multiplier passes for the
// polynomial, the target and the gain, the square root and a step that stores
// the result. With no move running the result goes straight to the store step.
// The next input beat is taken the cycle after a result is stored; a stalled
// output holds the engine in its final step.
module quintic_profile_sqrt_feedback_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire qpsf_pkg::in_t     in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output qpsf_pkg::out_t         out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [22:0]       cfg_data_i
);
  import qpsf_pkg::*;

  logic [15:0] gain_q, dur_q;
  logic [22:0] tol_q;
  logic signed [PosW-1:0] final_q, startp_q, meas_q;
  logic [TimeW-1:0] startt_q, elapsed_q;
  logic idle_q, ended_q;
  state_e st_q, st_d;
  logic [16:0] tau_q, t2_q;
  logic signed [PosW:0] err_q;
  out_t obuf_q;
  logic ovalid_q;

  mul_req_t mreq;
  logic mbusy, dbusy, sbusy, go_q;
  logic [2*MulW-1:0] prod, rnd;
  logic [47:0] quo;
  logic [23:0] root;
  logic [15:0] dur_eff;
  logic [16:0] tau_c, pcap;
  logic [19:0] inner;
  logic signed [PosW:0] span, target, err_c;
  logic [PosW:0] smag, emag, ferr, fmag;
  logic [PosW-1:0] tmag;
  logic [33:0] dmag;
  logic [15:0] mag16;
  logic accept;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      dur_q  <= 16'd100;
      tol_q  <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_GAIN:     gain_q <= cfg_data_i[15:0];
        REG_DURATION: dur_q  <= cfg_data_i[15:0];
        REG_TOL:      tol_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign dur_eff = (dur_q == '0) ? 16'd1 : dur_q;
  assign in_ready_o = (st_q == ST_IDLE) && !go_q;
  assign accept = in_valid_i && in_ready_o;
  assign rnd = prod + (2*MulW)'(32768);
  assign tau_c = (elapsed_q >= 32'(dur_eff)) ? 17'd65536 : quo[16:0];
  assign inner = 20'd655360 + 20'(6 * t2_q) - 20'(15 * tau_q);
  assign pcap = (rnd[32:16] > 17'd65536) ? 17'd65536 : rnd[32:16];
  assign span = (PosW+1)'(final_q) - (PosW+1)'(startp_q);
  assign smag = span[PosW] ? -span : span;
  assign tmag = rnd[PosW+15:16];
  assign target = span[PosW] ? (PosW+1)'(startp_q) - (PosW+1)'(tmag)
                             : (PosW+1)'(startp_q) + (PosW+1)'(tmag);
  assign err_c = target - (PosW+1)'(meas_q);
  assign emag = err_c[PosW] ? -err_c : err_c;
  assign ferr = (PosW+1)'(meas_q) - (PosW+1)'(final_q);
  assign fmag = ferr[PosW] ? -ferr : ferr;
  assign dmag = prod[35:2];
  assign mag16 = (dmag > 34'd16384) ? 16'd16384 : dmag[15:0];

  qpsf_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .busy_o(mbusy), .prod_o(prod));
  qpsf_div u_div (.clk_i, .rst_ni, .start_i(st_q == ST_IDLE && go_q && !idle_q),
    .num_i(elapsed_q), .den_i(dur_eff), .busy_o(dbusy), .quo_o(quo));
  qpsf_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(st_q == ST_TGT && !mbusy),
    .rad_i({8'h0, emag[PosW-1:0], 16'h0}), .busy_o(sbusy), .root_o(root));

  // Multiplier operand selection per phase; start fires as the phase ends.
  always_comb begin
    mreq = '0;
    case (st_q)
      ST_DIV:   if (!dbusy) begin
                  mreq.start = 1'b1; mreq.a = MulW'(tau_c); mreq.b = MulW'(tau_c);
                end
      ST_T2:    if (!mbusy) begin
                  mreq.start = 1'b1; mreq.a = MulW'(rnd[32:16]); mreq.b = MulW'(tau_q);
                end
      ST_T3:    if (!mbusy) begin
                  mreq.start = 1'b1; mreq.a = MulW'(rnd[32:16]); mreq.b = MulW'(inner);
                end
      ST_P:     if (!mbusy) begin
                  mreq.start = 1'b1; mreq.a = MulW'(smag); mreq.b = MulW'(pcap);
                end
      ST_SQRT:  if (!sbusy) begin
                  mreq.start = 1'b1; mreq.a = MulW'(gain_q); mreq.b = MulW'(root);
                end
      default:  ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (go_q) st_d = idle_q ? ST_OUT : ST_DIV;
      ST_DIV:   if (!dbusy) st_d = ST_T2;
      ST_T2:    if (!mbusy) st_d = ST_T3;
      ST_T3:    if (!mbusy) st_d = ST_P;
      ST_P:     if (!mbusy) st_d = ST_TGT;
      ST_TGT:   if (!mbusy) st_d = ST_SQRT;
      ST_SQRT:  if (!sbusy) st_d = ST_GAIN;
      ST_GAIN:  if (!mbusy) st_d = ST_OUT;
      ST_OUT:   if (!ovalid_q || out_ready_i) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      go_q     <= 1'b0;
      idle_q   <= 1'b1;
      final_q  <= '0;
      startp_q <= '0;
      startt_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        go_q <= 1'b1;
        if (in_data_i.commanded_position != final_q) begin
          final_q  <= in_data_i.commanded_position;
          startp_q <= in_data_i.measured_position;
          startt_q <= in_data_i.time_now;
          idle_q   <= 1'b0;
        end
      end else if (st_q == ST_IDLE) begin
        go_q <= 1'b0;
      end
      if (st_q == ST_OUT && st_d == ST_IDLE) begin
        ovalid_q <= 1'b1;
        if (ended_q) idle_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= in_data_i.measured_position;
      elapsed_q <= in_data_i.time_now -
        ((in_data_i.commanded_position != final_q) ? in_data_i.time_now : startt_q);
    end
    if (st_q == ST_IDLE && go_q) begin
      ended_q <= (elapsed_q >= 32'(dur_eff)) || (fmag < (PosW+1)'(tol_q));
    end
    if (st_q == ST_DIV && !dbusy) tau_q <= tau_c;
    if (st_q == ST_T2 && !mbusy) t2_q <= rnd[32:16];
    if (st_q == ST_TGT && !mbusy) err_q <= err_c;
    if (st_q == ST_OUT && st_d == ST_IDLE) begin
      if (idle_q) begin
        obuf_q.drive_power <= '0;
        obuf_q.move_done   <= 1'b1;
      end else begin
        obuf_q.drive_power <= (err_q == '0) ? 16'd0 :
                              (err_q[PosW] ? 16'd0 - mag16 : mag16);
        obuf_q.move_done   <= ended_q;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = obuf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second beat accepted during processing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.drive_power <= 16'sd16384) &&
                    (out_data_o.drive_power >= -16'sd16384))
    else $error("drive beyond full power");
endmodule

`default_nettype wire

[hdl/qpsf_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpsf_mul
// Shift-and-add multiplier, one bit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module qpsf_mul (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire qpsf_pkg::mul_req_t     req_i,
  output logic                        busy_o,
  output logic [2*qpsf_pkg::MulW-1:0] prod_o
);
  import qpsf_pkg::*;

  logic [2*MulW-1:0] acc_q, mcand_q;
  logic [MulW-1:0]   mplier_q;
  logic [6:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= 7'(MulW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q    <= '0;
      mcand_q  <= {{MulW{1'b0}}, req_i.a};
      mplier_q <= req_i.b;
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;
endmodule

`default_nettype wire

[hdl/qpsf_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpsf_div
// Restoring divider for tau, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpsf_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             busy_o,
  output logic [47:0]      quo_o
);
  logic [47:0] quo_q;
  logic [16:0] rem_q;
  logic [15:0] den_q;
  logic [5:0]  cnt_q;
  logic [16:0] trial;

  assign trial = {rem_q[15:0], quo_q[47]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 6'd48;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= {num_i, 16'h0};
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (!trial[16]) begin
        rem_q <= trial;
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= {rem_q[15:0], quo_q[47]};
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0) || start_i;
  assign quo_o  = quo_q;
endmodule

`default_nettype wire

[hdl/qpsf_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpsf_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qpsf_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] rad_i,
  output logic             busy_o,
  output logic [23:0]      root_o
);
  logic [47:0] rad_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [4:0]  cnt_q;
  logic [25:0] shifted, trial;

  assign shifted = {rem_q[23:0], rad_q[47:46]};
  assign trial   = shifted - {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 5'd24;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q <= rad_q << 2;
      if (!trial[25]) begin
        rem_q  <= trial;
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        root_q <= {root_q[22:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0) || start_i;
  assign root_o = root_q;
endmodule

`default_nettype wire
